// ----- sv/wav_header_parser_macros.svh -----
// Assertion macros for the WAV header parser.
// Used by the top level only; expects a clock named clk and a reset named rst.
`ifndef WAV_HEADER_PARSER_MACROS_SVH
`define WAV_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WAVP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wav_header_parser: check failed");

// Next-cycle implication, checked outside reset.
`define WAVP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wav_header_parser: check failed");

`endif

// ----- sv/wavp_pkg.sv -----
// Shared types, constants and tag tables for the WAV header parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wavp_pkg;

  localparam int SEARCH_LIMIT = 256;
  localparam int TRY_W = $clog2(SEARCH_LIMIT + 1);
  localparam int HEADER_LAST = 43;
  localparam logic [31:0] RESET_DEFAULT_RATE = 32'd16000;
  localparam logic [2:0] SIZE_BYTES = 3'd4;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_SCAN    = 5'b00010,
    PH_SKIP    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ACCEPT  = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    logic [31:0] sample_rate;
  } result_t;

  typedef struct packed {
    logic fire;
  } core_ctrl_t;

  function automatic logic [7:0] riff_tag(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = "R";
      2'd1:    c = "I";
      2'd2:    c = "F";
      default: c = "F";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] wave_tag(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = "W";
      2'd1:    c = "A";
      2'd2:    c = "V";
      default: c = "E";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] data_tag(input logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = "d";
      2'd1:    c = "a";
      2'd2:    c = "t";
      default: c = "a";
    endcase
    return c;
  endfunction

endpackage

// ----- sv/wavp_core.sv -----
// Parser state and per-byte decision logic for the WAV header parser.
// Depends on wavp_pkg; updates state on each fired item.
`timescale 1ns / 1ps

module wavp_core (
  input  logic                 clk,
  input  logic                 rst,
  input  wavp_pkg::core_ctrl_t ctrl,
  input  logic [7:0]           data_byte,
  input  logic                 first_byte,
  input  logic                 last_byte,
  input  logic [31:0]          default_rate,
  output wavp_pkg::result_t    result
);
  import wavp_pkg::*;

  phase_t             phase, phase_next;
  logic [5:0]         header_index, header_index_next;
  logic               magic_ok, magic_ok_next;
  logic               tag_ok_standard, tag_ok_standard_next;
  logic [31:0]        rate_capture, rate_capture_next;
  logic [TRY_W-1:0]   scan_tries, scan_tries_next;
  logic [1:0]         tag_position, tag_position_next;
  logic [2:0]         skip_left, skip_left_next;
  logic               tag_miss, tag_miss_next;

  logic               pre_accept;
  logic [TRY_W-1:0]   tries_inc;
  logic [31:0]        chosen_rate;
  logic [2:0]         skip_dec;

  always_comb begin
    // A first byte restarts parsing before the byte is examined.
    phase_next           = first_byte ? PH_HEADER : phase;
    header_index_next    = first_byte ? 6'd0 : header_index;
    magic_ok_next        = first_byte ? 1'b1 : magic_ok;
    tag_ok_standard_next = first_byte ? 1'b1 : tag_ok_standard;
    rate_capture_next    = first_byte ? 32'd0 : rate_capture;
    scan_tries_next      = first_byte ? '0 : scan_tries;
    tag_position_next    = first_byte ? 2'd0 : tag_position;
    skip_left_next       = first_byte ? 3'd0 : skip_left;
    tag_miss_next        = first_byte ? 1'b0 : tag_miss;

    result.kind        = KIND_HDR;
    result.payload     = 8'd0;
    result.sample_rate = 32'd0;

    pre_accept  = (phase_next == PH_HEADER) || (phase_next == PH_SCAN);
    tries_inc   = scan_tries_next + 1'b1;
    chosen_rate = 32'd0;
    skip_dec    = skip_left_next - 3'd1;

    case (phase_next)
      PH_HEADER: begin
        case (header_index_next[5:2])
          4'd0: if (data_byte != riff_tag(header_index_next[1:0])) magic_ok_next = 1'b0;
          4'd2: if (data_byte != wave_tag(header_index_next[1:0])) magic_ok_next = 1'b0;
          4'd6: begin
            case (header_index_next[1:0])
              2'd0:    rate_capture_next[7:0]   = rate_capture_next[7:0]   | data_byte;
              2'd1:    rate_capture_next[15:8]  = rate_capture_next[15:8]  | data_byte;
              2'd2:    rate_capture_next[23:16] = rate_capture_next[23:16] | data_byte;
              default: rate_capture_next[31:24] = rate_capture_next[31:24] | data_byte;
            endcase
          end
          4'd9: begin
            if (data_byte != data_tag(header_index_next[1:0])) tag_ok_standard_next = 1'b0;
          end
          default: ;
        endcase
        chosen_rate = (rate_capture_next == 32'd0) ? default_rate : rate_capture_next;
        if (header_index_next >= 6'(HEADER_LAST)) begin
          if (!magic_ok_next) begin
            result.kind = KIND_REJECT;
            phase_next  = PH_DONE;
          end else if (tag_ok_standard_next) begin
            result.kind        = KIND_ACCEPT;
            result.sample_rate = chosen_rate;
            phase_next         = PH_PAYLOAD;
          end else begin
            phase_next        = PH_SCAN;
            scan_tries_next   = '0;
            tag_position_next = 2'd0;
            tag_miss_next     = 1'b0;
          end
        end else begin
          header_index_next = header_index_next + 6'd1;
        end
      end
      PH_SCAN: begin
        chosen_rate = (rate_capture_next == 32'd0) ? default_rate : rate_capture_next;
        if (tag_position_next == 2'd0) begin
          if (data_byte == data_tag(2'd0)) begin
            tag_position_next = 2'd1;
          end else begin
            // Failed try: count it and give up at the limit.
            scan_tries_next = tries_inc;
            tag_miss_next   = 1'b0;
            if (tries_inc >= TRY_W'(SEARCH_LIMIT)) begin
              result.kind = KIND_REJECT;
              phase_next  = PH_DONE;
            end
          end
        end else begin
          if (data_byte != data_tag(tag_position_next)) tag_miss_next = 1'b1;
          if (tag_position_next == 2'd3) begin
            tag_position_next = 2'd0;
            if (!tag_miss_next) begin
              result.kind        = KIND_ACCEPT;
              result.sample_rate = chosen_rate;
              phase_next         = PH_SKIP;
              skip_left_next     = SIZE_BYTES;
            end else begin
              scan_tries_next = tries_inc;
              tag_miss_next   = 1'b0;
              if (tries_inc >= TRY_W'(SEARCH_LIMIT)) begin
                result.kind = KIND_REJECT;
                phase_next  = PH_DONE;
              end
            end
          end else begin
            tag_position_next = tag_position_next + 2'd1;
          end
        end
      end
      PH_SKIP: begin
        skip_left_next = skip_dec;
        if (skip_dec == 3'd0) phase_next = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        result.kind    = KIND_PAYLOAD;
        result.payload = data_byte;
      end
      default: ;
    endcase

    // End of file: no verdict yet means rejection.
    if (last_byte) begin
      if (pre_accept && (result.kind == KIND_HDR)) result.kind = KIND_REJECT;
      phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_index    <= 6'd0;
      magic_ok        <= 1'b1;
      tag_ok_standard <= 1'b1;
      rate_capture    <= 32'd0;
      scan_tries      <= '0;
      tag_position    <= 2'd0;
      skip_left       <= 3'd0;
      tag_miss        <= 1'b0;
    end else if (ctrl.fire) begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      magic_ok        <= magic_ok_next;
      tag_ok_standard <= tag_ok_standard_next;
      rate_capture    <= rate_capture_next;
      scan_tries      <= scan_tries_next;
      tag_position    <= tag_position_next;
      skip_left       <= skip_left_next;
      tag_miss        <= tag_miss_next;
    end
  end

endmodule

// ----- sv/wavp_out_reg.sv -----
// Result register of the WAV header parser: holds one item until taken.
// Depends on wavp_pkg for the result type.
`timescale 1ns / 1ps

module wavp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  wavp_pkg::result_t result_in,
  input  logic              take,
  output logic              valid,
  output wavp_pkg::result_t result_out
);
  import wavp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

// ----- sv/wav_header_parser.sv -----
// Top level of the WAV header parser: input register, parser core, result register.
// Depends on wavp_pkg, wavp_core, wavp_out_reg and wav_header_parser_macros.svh.
`timescale 1ns / 1ps

// Takes a file one byte per item and returns one result item per byte: header
// verdict with the sample rate, payload bytes, or a marker for header, scanned
// and skipped bytes and for bytes after a rejection. Throughput is one item per
// clock while the output is not stalled; each result passes through the input
// register and the result register around the parser update. A stalled output
// holds the input register, so up to two items are in flight. default_rate is
// written through the cfg channel, which is always ready; write it only while
// no item is in flight.
module wav_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  payload,
  output logic [31:0] sample_rate,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import wavp_pkg::*;

  `include "wav_header_parser_macros.svh"

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_first;
  logic        s1_last;
  logic        s1_move;
  logic [31:0] default_rate;
  core_ctrl_t  ctrl;
  result_t     core_result;
  result_t     out_result;

  assign cfg_ready = 1'b1;
  assign s1_move   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_move;
  assign ctrl.fire = s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_rate <= RESET_DEFAULT_RATE;
    end else if (cfg_valid && cfg_ready) begin
      default_rate <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= data_byte;
      s1_first <= first_byte;
      s1_last  <= last_byte;
    end
  end

  wavp_core u_core (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .data_byte    (s1_byte),
    .first_byte   (s1_first),
    .last_byte    (s1_last),
    .default_rate (default_rate),
    .result       (core_result)
  );

  wavp_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (s1_move),
    .result_in  (core_result),
    .take       (out_ready),
    .valid      (out_valid),
    .result_out (out_result)
  );

  assign kind        = out_result.kind;
  assign payload     = out_result.payload;
  assign sample_rate = out_result.sample_rate;

  // Hold the staged item while the result register is blocked.
  `WAVP_ASSERT_NEXT(a_stage_holds, s1_valid && out_valid && !out_ready, s1_valid)
  // Back-pressure on input only when the stage is occupied.
  `WAVP_ASSERT_NOW(a_ready_means_room, !in_ready, s1_valid && out_valid && !out_ready)
  // A taken result with nothing behind it leaves the output empty.
  `WAVP_ASSERT_NEXT(a_drain, out_valid && out_ready && !s1_valid, !out_valid)
  // Rate field is zero outside an accept.
  `WAVP_ASSERT_NOW(a_fields_clean, out_valid && (kind != KIND_ACCEPT), sample_rate == 32'd0)

endmodule
